// ===== sv/memory_self_test_sequencer_assert.svh =====
`ifndef MEMORY_SELF_TEST_SEQUENCER_ASSERT_SVH
`define MEMORY_SELF_TEST_SEQUENCER_ASSERT_SVH

// same-cycle implication, off during reset
`define MST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mst check failed");

// next-cycle implication, off during reset
`define MST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mst check failed");

// next-cycle implication, always on
`define MST_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("mst check failed");

`endif

// ===== sv/mst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mst_pkg;

    localparam int ADDR_BITS_DEFAULT  = 24;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int WORD_ADDR_W = 30;
    localparam int REGION_W    = 25;
    localparam int XDATA_W     = 32;
    localparam int TEST_MASK_W = 3;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 104;

    localparam logic [REGION_W-1:0] REGION_WORDS_RESET = 25'h100_0000;

    localparam logic [63:0] PAT_HI = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [63:0] PAT_LO = 64'h5555_5555_5555_5555;

    localparam logic MODE_START = 1'b0;

    localparam logic [1:0] TEST_DATA_BUS = 2'd0;
    localparam logic [1:0] TEST_ADDR_BUS = 2'd1;
    localparam logic [1:0] TEST_DEVICE   = 2'd2;

    localparam logic REG_BASE_WORD    = 1'b0;
    localparam logic REG_REGION_WORDS = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_DONE        = 4'd1,
        PH_DB_WRITE    = 4'd2,
        PH_DB_READ     = 4'd3,
        PH_AB_FILL     = 4'd4,
        PH_AB_ANTI0    = 4'd5,
        PH_AB_CHKHI    = 4'd6,
        PH_AB_RESTORE0 = 4'd7,
        PH_AB_TWRITE   = 4'd8,
        PH_AB_READ0    = 4'd9,
        PH_AB_CHKLO    = 4'd10,
        PH_AB_TRESTORE = 4'd11,
        PH_DV_FILL     = 4'd12,
        PH_DV_CHECK    = 4'd13,
        PH_DV_INVERT   = 4'd14,
        PH_DV_VERIFY   = 4'd15
    } t_phase;

    typedef enum logic [1:0] {
        ACC_NONE  = 2'd0,
        ACC_WRITE = 2'd1,
        ACC_READ  = 2'd2
    } t_access;

    typedef enum logic [1:0] {
        REP_NONE = 2'd0,
        REP_PASS = 2'd1,
        REP_FAIL = 2'd2
    } t_report;

    typedef struct packed {
        logic [WORD_ADDR_W-1:0] base_word;
        logic [REGION_W-1:0]    region_words;
    } t_cfg;

    typedef struct packed {
        t_access                access;
        logic [WORD_ADDR_W-1:0] word_address;
        logic [XDATA_W-1:0]     write_data;
        t_report                report;
        logic [1:0]             test_id;
        logic [XDATA_W-1:0]     fail_value;
        logic                   run_done;
        logic                   any_failed;
    } t_result;

    // base plus offset, wrapping in the word address space
    function automatic logic [WORD_ADDR_W-1:0] waddr(
        input logic [WORD_ADDR_W-1:0] base,
        input logic [31:0]            off
    );
        return base + off[WORD_ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/mst_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mst_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_psel,
    input  wire logic                           i_penable,
    input  wire logic                           i_pwrite,
    input  wire logic [mst_pkg::APB_ADDR_W-1:0] i_paddr,
    input  wire logic [mst_pkg::APB_DATA_W-1:0] i_pwdata,
    output logic [mst_pkg::APB_DATA_W-1:0]      o_prdata,
    output logic                                o_pready,
    output mst_pkg::t_cfg                       o_cfg
);
    import mst_pkg::*;

    logic [WORD_ADDR_W-1:0] r_base_word;
    logic [REGION_W-1:0]    r_region_words;
    logic                   wr_en;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_word    <= '0;
            r_region_words <= REGION_WORDS_RESET;
        end else if (wr_en) begin
            case (i_paddr[2])
                REG_BASE_WORD:    r_base_word    <= i_pwdata[WORD_ADDR_W-1:0];
                REG_REGION_WORDS: r_region_words <= i_pwdata[REGION_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[2])
            REG_BASE_WORD:    o_prdata = APB_DATA_W'(r_base_word);
            REG_REGION_WORDS: o_prdata = APB_DATA_W'(r_region_words);
            default:          o_prdata = '0;
        endcase
    end

    assign o_cfg.base_word    = r_base_word;
    assign o_cfg.region_words = r_region_words;

endmodule

`default_nettype wire

// ===== sv/mst_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mst_step #(
    parameter int ADDR_BITS  = mst_pkg::ADDR_BITS_DEFAULT,
    parameter int DATA_WIDTH = mst_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_fire,
    input  wire logic                            i_mode,
    input  wire logic [mst_pkg::TEST_MASK_W-1:0] i_test_mask,
    input  wire logic [mst_pkg::XDATA_W-1:0]     i_read_data,
    input  wire mst_pkg::t_cfg                   i_cfg,
    output mst_pkg::t_result                     o_result
);
    import mst_pkg::*;

    localparam int OW = ADDR_BITS + 1;
    localparam logic [31:0] TOP_WORDS = 32'(64'd1 << ADDR_BITS);
    localparam logic [DATA_WIDTH-1:0] PAT_HI_W = DATA_WIDTH'(PAT_HI);
    localparam logic [DATA_WIDTH-1:0] PAT_LO_W = DATA_WIDTH'(PAT_LO);

    t_phase                 r_phase, n_phase;
    logic [1:0]             r_test, n_test;
    logic [TEST_MASK_W-1:0] r_enabled, n_enabled;
    logic [OW-1:0]          r_walk, n_walk;
    logic [OW-1:0]          r_probe, n_probe;
    logic [DATA_WIDTH-1:0]  r_pattern, n_pattern;
    logic [DATA_WIDTH-1:0]  r_expected, n_expected;
    logic                   r_pending, n_pending;
    logic                   r_failure, n_failure;

    logic [31:0]           words;
    logic [31:0]           mask;
    logic [DATA_WIDTH-1:0] rd_word;
    logic [OW-1:0]         walk_sh;
    logic [OW-1:0]         probe_sh;
    logic [OW-1:0]         walk_inc;
    logic                  walk_end;
    logic [DATA_WIDTH-1:0] pattern_sh;
    logic                  failed;
    logic                  passed;
    logic                  start;
    logic [1:0]            start_t;
    logic                  found;
    logic [1:0]            sel;
    logic                  active;
    logic                  is_rd;
    logic [OW-1:0]         off;
    logic [DATA_WIDTH-1:0] d;
    logic [DATA_WIDTH-1:0] cnt;

    function automatic logic in_mask(input logic [OW-1:0] o, input logic [31:0] m);
        return (32'(o) & m) != 32'd0;
    endfunction

    // region size clamped to one word at least and the address span at most
    always_comb begin
        words = 32'(i_cfg.region_words);
        if (words == 32'd0) begin
            words = 32'd1;
        end
        if (words > TOP_WORDS) begin
            words = TOP_WORDS;
        end
    end

    assign mask       = words - 32'd1;
    assign rd_word    = DATA_WIDTH'(64'(i_read_data));
    assign walk_sh    = r_walk << 1;
    assign probe_sh   = r_probe << 1;
    assign walk_inc   = r_walk + OW'(1);
    assign walk_end   = 32'(walk_inc) >= words;
    assign pattern_sh = r_pattern << 1;

    // next state: judge the pending read, advance the phase, start the next test
    always_comb begin
        n_phase   = r_phase;
        n_test    = r_test;
        n_enabled = r_enabled;
        n_walk    = r_walk;
        n_probe   = r_probe;
        n_pattern = r_pattern;
        n_failure = r_failure;
        failed    = 1'b0;
        passed    = 1'b0;
        start     = 1'b0;
        start_t   = TEST_DATA_BUS;
        found     = 1'b0;
        sel       = TEST_DATA_BUS;
        if (i_fire) begin
            if (i_mode == MODE_START) begin
                n_enabled = i_test_mask;
                n_failure = 1'b0;
                start     = 1'b1;
            end else if (r_phase != PH_IDLE && r_phase != PH_DONE) begin
                // the probe's own offset is read but not judged
                failed = r_pending && (rd_word != r_expected)
                         && !(r_phase == PH_AB_CHKLO && r_walk == r_probe);
                if (!failed) begin
                    case (r_phase)
                        PH_DB_WRITE: n_phase = PH_DB_READ;
                        PH_DB_READ: begin
                            n_pattern = pattern_sh;
                            if (pattern_sh == '0) begin
                                passed = 1'b1;
                            end else begin
                                n_phase = PH_DB_WRITE;
                            end
                        end
                        PH_AB_FILL: begin
                            n_walk = walk_sh;
                            if (!in_mask(walk_sh, mask)) begin
                                n_phase = PH_AB_ANTI0;
                            end
                        end
                        PH_AB_ANTI0: begin
                            n_walk  = OW'(1);
                            n_phase = mask[0] ? PH_AB_CHKHI : PH_AB_RESTORE0;
                        end
                        PH_AB_CHKHI: begin
                            n_walk = walk_sh;
                            if (!in_mask(walk_sh, mask)) begin
                                n_phase = PH_AB_RESTORE0;
                            end
                        end
                        PH_AB_RESTORE0: begin
                            n_probe = OW'(1);
                            if (!mask[0]) begin
                                passed = 1'b1;
                            end else begin
                                n_phase = PH_AB_TWRITE;
                            end
                        end
                        PH_AB_TWRITE: n_phase = PH_AB_READ0;
                        PH_AB_READ0: begin
                            n_walk  = OW'(1);
                            n_phase = mask[0] ? PH_AB_CHKLO : PH_AB_TRESTORE;
                        end
                        PH_AB_CHKLO: begin
                            n_walk = walk_sh;
                            if (!in_mask(walk_sh, mask)) begin
                                n_phase = PH_AB_TRESTORE;
                            end
                        end
                        PH_AB_TRESTORE: begin
                            n_probe = probe_sh;
                            if (!in_mask(probe_sh, mask)) begin
                                passed = 1'b1;
                            end else begin
                                n_phase = PH_AB_TWRITE;
                            end
                        end
                        PH_DV_FILL: begin
                            if (walk_end) begin
                                n_walk  = '0;
                                n_phase = PH_DV_CHECK;
                            end else begin
                                n_walk = walk_inc;
                            end
                        end
                        PH_DV_CHECK: n_phase = PH_DV_INVERT;
                        PH_DV_INVERT: begin
                            if (walk_end) begin
                                n_walk  = '0;
                                n_phase = PH_DV_VERIFY;
                            end else begin
                                n_walk = walk_inc;
                            end
                        end
                        default: begin
                            n_walk = walk_inc;
                            passed = walk_end;
                        end
                    endcase
                end
                if (failed || passed) begin
                    if (failed) begin
                        n_failure = 1'b1;
                    end
                    start   = 1'b1;
                    start_t = r_test + 2'd1;
                end
            end
        end
        if (start) begin
            for (int t = 0; t < 3; t++) begin
                if (!found && (2'(t) >= start_t) && n_enabled[t]) begin
                    found = 1'b1;
                    sel   = 2'(t);
                end
            end
            n_phase = PH_DONE;
            if (found) begin
                n_test = sel;
                case (sel)
                    TEST_DATA_BUS: begin
                        n_pattern = DATA_WIDTH'(1);
                        n_phase   = PH_DB_WRITE;
                    end
                    TEST_ADDR_BUS: begin
                        n_walk  = OW'(1);
                        n_phase = mask[0] ? PH_AB_FILL : PH_AB_ANTI0;
                    end
                    TEST_DEVICE: begin
                        n_walk  = '0;
                        n_phase = PH_DV_FILL;
                    end
                    default: n_phase = PH_DONE;
                endcase
            end
        end
    end

    // outputs: access of the new phase and the report of the finished test
    always_comb begin
        is_rd  = 1'b0;
        off    = '0;
        d      = '0;
        active = (n_phase != PH_IDLE) && (n_phase != PH_DONE);
        cnt    = DATA_WIDTH'(64'(n_walk) + 64'd1);
        case (n_phase)
            PH_DB_WRITE: d = n_pattern;
            PH_DB_READ: begin
                is_rd = 1'b1;
                d     = n_pattern;
            end
            PH_AB_FILL: begin
                off = n_walk;
                d   = PAT_HI_W;
            end
            PH_AB_ANTI0: d = PAT_LO_W;
            PH_AB_CHKHI: begin
                is_rd = 1'b1;
                off   = n_walk;
                d     = PAT_HI_W;
            end
            PH_AB_RESTORE0: d = PAT_HI_W;
            PH_AB_TWRITE: begin
                off = n_probe;
                d   = PAT_LO_W;
            end
            PH_AB_READ0: begin
                is_rd = 1'b1;
                d     = PAT_HI_W;
            end
            PH_AB_CHKLO: begin
                is_rd = 1'b1;
                off   = n_walk;
                d     = PAT_HI_W;
            end
            PH_AB_TRESTORE: begin
                off = n_probe;
                d   = PAT_HI_W;
            end
            PH_DV_FILL: begin
                off = n_walk;
                d   = cnt;
            end
            PH_DV_CHECK: begin
                is_rd = 1'b1;
                off   = n_walk;
                d     = cnt;
            end
            PH_DV_INVERT: begin
                off = n_walk;
                d   = ~cnt;
            end
            PH_DV_VERIFY: begin
                is_rd = 1'b1;
                off   = n_walk;
                d     = ~cnt;
            end
            default: ;
        endcase

        o_result = '0;
        if (active) begin
            o_result.access       = is_rd ? ACC_READ : ACC_WRITE;
            o_result.word_address = waddr(i_cfg.base_word, 32'(off));
            if (!is_rd) begin
                o_result.write_data = XDATA_W'(64'(d));
            end
        end
        if (failed) begin
            o_result.report  = REP_FAIL;
            o_result.test_id = r_test;
            case (r_phase)
                PH_DB_READ: o_result.fail_value = XDATA_W'(64'(r_pattern));
                PH_AB_READ0, PH_AB_CHKLO:
                    o_result.fail_value = XDATA_W'(waddr(i_cfg.base_word, 32'(r_probe)));
                default:
                    o_result.fail_value = XDATA_W'(waddr(i_cfg.base_word, 32'(r_walk)));
            endcase
        end else if (passed) begin
            o_result.report  = REP_PASS;
            o_result.test_id = r_test;
        end
        o_result.run_done   = (n_phase == PH_DONE);
        o_result.any_failed = (n_phase != PH_IDLE) && n_failure;

        n_pending  = i_fire ? (active && is_rd) : r_pending;
        n_expected = (i_fire && active && is_rd) ? d : r_expected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_test     <= '0;
            r_enabled  <= '0;
            r_walk     <= '0;
            r_probe    <= '0;
            r_pattern  <= '0;
            r_expected <= '0;
            r_pending  <= 1'b0;
            r_failure  <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_test     <= n_test;
            r_enabled  <= n_enabled;
            r_walk     <= n_walk;
            r_probe    <= n_probe;
            r_pattern  <= n_pattern;
            r_expected <= n_expected;
            r_pending  <= n_pending;
            r_failure  <= n_failure;
        end
    end

endmodule

`default_nettype wire

// ===== sv/memory_self_test_sequencer.sv =====
// Memory self-test sequencer: data bus, address bus and device tests.
// Input stream (s_*): each item is either a start (tuser 0, tdata carries the
// test mask) or a step (tuser 1, tdata carries the read data that answers the
// read request of the previous result). Every input item gives exactly one
// result item on the output stream (m_*): at most one memory access, an
// optional pass/fail report for a test, and run status.
// Configuration (APB): base word at 0x0, region size in words at 0x4; write
// only while the block holds no item.
// Flow: an accepted item is held in the input register, and its result is
// registered in the result register. One item per cycle is sustained while
// m_tready stays high; the step logic's next-state loop is combinational.
// Stall: an item waits in the input register while the result register is full
// and m_tready is low; only then, with both occupied, does s_tready drop.
// Reset (synchronous, active low): both stages empty, phase idle, base word 0,
// region size 2^24 words.
`timescale 1ns / 1ps
`default_nettype none

module memory_self_test_sequencer #(
    parameter int ADDR_BITS  = mst_pkg::ADDR_BITS_DEFAULT,
    parameter int DATA_WIDTH = mst_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // test_mask[2:0], read_data[34:3], zero pad
    input  wire logic [mst_pkg::S_TDATA_W-1:0]  s_tdata,
    // mode
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // word_address[29:0], write_data[61:30], report[63:62], test_id[65:64],
    // fail_value[97:66], run_done[98], any_failed[99], zero pad
    output logic [mst_pkg::M_TDATA_W-1:0]       m_tdata,
    // access
    output logic [1:0]                          m_tuser,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mst_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [mst_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mst_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import mst_pkg::*;

    t_cfg                   cfg;
    t_result                res;
    logic                   s_fire;
    logic                   advance;

    logic                   r_in_valid;
    logic                   r_in_mode;
    logic [TEST_MASK_W-1:0] r_in_mask;
    logic [XDATA_W-1:0]     r_in_rdata;
    logic                   r_out_valid;
    t_result                r_out;

    assign advance  = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in_mode  <= s_tuser;
            r_in_mask  <= s_tdata[TEST_MASK_W-1:0];
            r_in_rdata <= s_tdata[TEST_MASK_W +: XDATA_W];
        end
    end

    mst_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    mst_step #(
        .ADDR_BITS  (ADDR_BITS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_mode      (r_in_mode),
        .i_test_mask (r_in_mask),
        .i_read_data (r_in_rdata),
        .i_cfg       (cfg),
        .o_result    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out.access;
    assign m_tdata  = {4'b0000, r_out.any_failed, r_out.run_done, r_out.fail_value,
                       r_out.test_id, r_out.report, r_out.write_data, r_out.word_address};

endmodule

`default_nettype wire

// ===== sv/mst_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "memory_self_test_sequencer_assert.svh"

module mst_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_s_tready,
    input wire logic                          i_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [mst_pkg::M_TDATA_W-1:0] i_m_tdata,
    input wire logic [1:0]                    i_m_tuser
);
    import mst_pkg::*;

    logic                 stalled;
    logic [M_TDATA_W+1:0] out_word;
    logic                 no_access;
    logic                 no_report;

    assign stalled   = i_m_tvalid && !i_m_tready;
    assign out_word  = {i_m_tuser, i_m_tdata};
    assign no_access = i_m_tvalid && (i_m_tuser == ACC_NONE);
    assign no_report = i_m_tvalid && (i_m_tdata[63:62] == REP_NONE);

    `MST_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_m_tvalid)
    `MST_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, stalled, i_m_tvalid && $stable(out_word))
    `MST_ASSERT_NOW(a_no_access_quiet, i_clk, i_rst_n, no_access, i_m_tdata[61:0] == '0)
    `MST_ASSERT_NOW(a_no_report_quiet, i_clk, i_rst_n, no_report, i_m_tdata[97:64] == '0)
    `MST_ASSERT_NOW(a_empty_takes, i_clk, i_rst_n, !i_m_tvalid, i_s_tready)

endmodule

bind memory_self_test_sequencer mst_checker u_mst_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (s_tready),
    .i_m_tvalid (m_tvalid),
    .i_m_tready (m_tready),
    .i_m_tdata  (m_tdata),
    .i_m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/memory_self_test_sequencer_test.sv =====
`timescale 1ns / 1ps

module memory_self_test_sequencer_test;
    import mst_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 150;
    localparam logic MODE_STEP = ~MODE_START;
    localparam logic [APB_ADDR_W-1:0] ADDR_BASE_WORD = {REG_BASE_WORD, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_REGION_WORDS = {REG_REGION_WORDS, 2'b00};
    localparam logic [REGION_W-1:0] REGION_TOP = 25'h100_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tready = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    wire s_tready;
    wire m_tvalid;
    wire [M_TDATA_W-1:0] m_tdata;
    wire [1:0] m_tuser;
    wire [APB_DATA_W-1:0] prdata;
    wire pready;

    memory_self_test_sequencer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // sequencer mirror
    t_phase mst_phase;
    logic [1:0] mst_test;
    logic [2:0] mst_enabled;
    logic [REGION_W-1:0] mst_walk;
    logic [REGION_W-1:0] mst_probe;
    logic [31:0] mst_pattern;
    logic [31:0] mst_expect;
    logic mst_read_pending;
    logic mst_failed;
    logic [WORD_ADDR_W-1:0] cfg_base;
    logic [REGION_W-1:0] cfg_region;

    t_result expected_results[$];
    int mismatches = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    int rx_hold = 0;
    bit gaps_on = 1'b1;

    task automatic reset_model();
        mst_phase = PH_IDLE;
        mst_test = '0;
        mst_enabled = '0;
        mst_walk = '0;
        mst_probe = '0;
        mst_pattern = '0;
        mst_expect = '0;
        mst_read_pending = 1'b0;
        mst_failed = 1'b0;
        cfg_base = '0;
        cfg_region = REGION_WORDS_RESET;
    endtask

    function automatic bit running();
        return mst_phase != PH_IDLE && mst_phase != PH_DONE;
    endfunction

    function automatic logic [REGION_W-1:0] region_size();
        if (cfg_region == '0) return 25'd1;
        if (cfg_region > REGION_TOP) return REGION_TOP;
        return cfg_region;
    endfunction

    function automatic bit below_mask(logic [REGION_W-1:0] off);
        return (off & (region_size() - 25'd1)) != '0;
    endfunction

    function automatic logic [WORD_ADDR_W-1:0] region_addr(logic [REGION_W-1:0] off);
        return cfg_base + WORD_ADDR_W'(off);
    endfunction

    function automatic void enter_test(logic [1:0] t);
        mst_test = t;
        mst_read_pending = 1'b0;
        case (t)
            TEST_DATA_BUS: begin
                mst_pattern = 32'd1;
                mst_phase = PH_DB_WRITE;
            end
            TEST_ADDR_BUS: begin
                mst_walk = 25'd1;
                mst_phase = below_mask(25'd1) ? PH_AB_FILL : PH_AB_ANTI0;
            end
            default: begin
                mst_walk = '0;
                mst_phase = PH_DV_FILL;
            end
        endcase
    endfunction

    function automatic void next_enabled(int first);
        for (int t = first; t < 3; t++) begin
            if (mst_enabled[t]) begin
                enter_test(2'(t));
                return;
            end
        end
        mst_phase = PH_DONE;
    endfunction

    // moves past the access just done, returns 1 when the test has passed
    function automatic bit advance_phase();
        case (mst_phase)
            PH_DB_WRITE: mst_phase = PH_DB_READ;
            PH_DB_READ: begin
                mst_pattern = mst_pattern << 1;
                if (mst_pattern == '0) return 1'b1;
                mst_phase = PH_DB_WRITE;
            end
            PH_AB_FILL: begin
                mst_walk = mst_walk << 1;
                if (!below_mask(mst_walk)) mst_phase = PH_AB_ANTI0;
            end
            PH_AB_ANTI0: begin
                mst_walk = 25'd1;
                mst_phase = below_mask(25'd1) ? PH_AB_CHKHI : PH_AB_RESTORE0;
            end
            PH_AB_CHKHI: begin
                mst_walk = mst_walk << 1;
                if (!below_mask(mst_walk)) mst_phase = PH_AB_RESTORE0;
            end
            PH_AB_RESTORE0: begin
                mst_probe = 25'd1;
                if (!below_mask(25'd1)) return 1'b1;
                mst_phase = PH_AB_TWRITE;
            end
            PH_AB_TWRITE: mst_phase = PH_AB_READ0;
            PH_AB_READ0: begin
                mst_walk = 25'd1;
                mst_phase = below_mask(25'd1) ? PH_AB_CHKLO : PH_AB_TRESTORE;
            end
            PH_AB_CHKLO: begin
                mst_walk = mst_walk << 1;
                if (!below_mask(mst_walk)) mst_phase = PH_AB_TRESTORE;
            end
            PH_AB_TRESTORE: begin
                mst_probe = mst_probe << 1;
                if (!below_mask(mst_probe)) return 1'b1;
                mst_phase = PH_AB_TWRITE;
            end
            PH_DV_FILL: begin
                mst_walk = mst_walk + 25'd1;
                if (mst_walk >= region_size()) begin
                    mst_walk = '0;
                    mst_phase = PH_DV_CHECK;
                end
            end
            PH_DV_CHECK: mst_phase = PH_DV_INVERT;
            PH_DV_INVERT: begin
                mst_walk = mst_walk + 25'd1;
                if (mst_walk >= region_size()) begin
                    mst_walk = '0;
                    mst_phase = PH_DV_VERIFY;
                end
            end
            default: begin
                mst_walk = mst_walk + 25'd1;
                return mst_walk >= region_size();
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void issue_access(inout t_result r);
        logic [31:0] count;
        logic [REGION_W-1:0] off;
        logic [31:0] data;
        bit rd;
        count = 32'(mst_walk) + 32'd1;
        off = '0;
        data = '0;
        rd = 1'b0;
        case (mst_phase)
            PH_DB_WRITE: data = mst_pattern;
            PH_DB_READ: begin
                rd = 1'b1;
                data = mst_pattern;
            end
            PH_AB_FILL: begin
                off = mst_walk;
                data = PAT_HI[31:0];
            end
            PH_AB_ANTI0: data = PAT_LO[31:0];
            PH_AB_CHKHI: begin
                rd = 1'b1;
                off = mst_walk;
                data = PAT_HI[31:0];
            end
            PH_AB_RESTORE0: data = PAT_HI[31:0];
            PH_AB_TWRITE: begin
                off = mst_probe;
                data = PAT_LO[31:0];
            end
            PH_AB_READ0: begin
                rd = 1'b1;
                data = PAT_HI[31:0];
            end
            PH_AB_CHKLO: begin
                rd = 1'b1;
                off = mst_walk;
                data = PAT_HI[31:0];
            end
            PH_AB_TRESTORE: begin
                off = mst_probe;
                data = PAT_HI[31:0];
            end
            PH_DV_FILL: begin
                off = mst_walk;
                data = count;
            end
            PH_DV_CHECK: begin
                rd = 1'b1;
                off = mst_walk;
                data = count;
            end
            PH_DV_INVERT: begin
                off = mst_walk;
                data = ~count;
            end
            default: begin
                rd = 1'b1;
                off = mst_walk;
                data = ~count;
            end
        endcase
        r.word_address = region_addr(off);
        if (rd) begin
            r.access = ACC_READ;
            mst_expect = data;
            mst_read_pending = 1'b1;
        end else begin
            r.access = ACC_WRITE;
            r.write_data = data;
            mst_read_pending = 1'b0;
        end
    endfunction

    function automatic t_result predict_item(logic mode, logic [2:0] mask,
                                             logic [31:0] rdata);
        t_result r;
        bit failed;
        bit passed;
        r = '0;
        failed = 1'b0;
        passed = 1'b0;
        if (mode == MODE_START) begin
            mst_enabled = mask;
            mst_failed = 1'b0;
            mst_read_pending = 1'b0;
            next_enabled(0);
        end else if (running()) begin
            // the read at the probed offset itself is not judged
            if (mst_read_pending && rdata != mst_expect
                    && !(mst_phase == PH_AB_CHKLO && mst_walk == mst_probe)) begin
                failed = 1'b1;
                if (mst_phase == PH_DB_READ)
                    r.fail_value = mst_pattern;
                else if (mst_phase == PH_AB_READ0 || mst_phase == PH_AB_CHKLO)
                    r.fail_value = 32'(region_addr(mst_probe));
                else
                    r.fail_value = 32'(region_addr(mst_walk));
            end
            mst_read_pending = 1'b0;
            if (!failed) passed = advance_phase();
            if (failed || passed) begin
                r.report = failed ? REP_FAIL : REP_PASS;
                r.test_id = mst_test;
                if (failed) mst_failed = 1'b1;
                next_enabled(int'(mst_test) + 1);
            end
        end
        if (running()) issue_access(r);
        r.run_done = (mst_phase == PH_DONE);
        r.any_failed = (mst_phase == PH_IDLE) ? 1'b0 : mst_failed;
        return r;
    endfunction

    // read data for the next step: mostly the right answer, sometimes a fault
    function automatic logic [31:0] read_answer(int bad_pct);
        if (!mst_read_pending) return $urandom();
        if (mst_phase == PH_AB_CHKLO && mst_walk == mst_probe && $urandom_range(0, 1))
            return ~mst_expect;
        if ($urandom_range(0, 99) < bad_pct) begin
            case ($urandom_range(0, 2))
                0: return $urandom();
                1: return mst_expect ^ (32'd1 << $urandom_range(0, 31));
                default: return ~mst_expect;
            endcase
        end
        return mst_expect;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h, got %h", name, want, got);
        end
    endfunction

    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: result item with none expected, tdata %h", m_tdata);
            return;
        end
        want = expected_results.pop_front();
        check_field("access", want.access, m_tuser);
        check_field("word_address", want.word_address, m_tdata[29:0]);
        check_field("write_data", want.write_data, m_tdata[61:30]);
        check_field("report", want.report, m_tdata[63:62]);
        check_field("test_id", want.test_id, m_tdata[65:64]);
        check_field("fail_value", want.fail_value, m_tdata[97:66]);
        check_field("run_done", want.run_done, m_tdata[98]);
        check_field("any_failed", want.any_failed, m_tdata[99]);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            check_result();
            rx_hold = gaps_on ? $urandom_range(0, 13) : 0;
        end else if (rx_hold > 0) begin
            rx_hold--;
        end
        m_tready <= (rx_hold == 0);
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(logic mode, logic [2:0] mask, logic [31:0] rdata);
        int gap;
        gap = gaps_on ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= S_TDATA_W'({rdata, mask});
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (mode == MODE_START || running()) items_sent++;
        expected_results.push_back(predict_item(mode, mask, rdata));
    endtask

    task automatic step(int bad_pct);
        send_item(MODE_STEP, 3'($urandom()), read_answer(bad_pct));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [APB_ADDR_W-1:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        if (addr == ADDR_BASE_WORD)
            cfg_base = data[WORD_ADDR_W-1:0];
        else
            cfg_region = data[REGION_W-1:0];
    endtask

    task automatic reg_check(logic [APB_ADDR_W-1:0] addr, logic [31:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        check_field("prdata", want, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(logic [31:0] base, logic [31:0] region);
        drain();
        reg_write(ADDR_BASE_WORD, base);
        reg_write(ADDR_REGION_WORDS, region);
        reg_check(ADDR_BASE_WORD, 32'(cfg_base));
        reg_check(ADDR_REGION_WORDS, 32'(cfg_region));
    endtask

    task automatic run_to_end(int bad_pct, int limit);
        int n;
        n = 0;
        while (running() && n < limit) begin
            step(bad_pct);
            n++;
        end
    endtask

    task automatic test_idle_and_empty();
        reg_check(ADDR_BASE_WORD, 32'(cfg_base));
        reg_check(ADDR_REGION_WORDS, 32'(cfg_region));
        send_item(MODE_STEP, 3'd7, 32'hFFFF_FFFF);
        send_item(MODE_STEP, 3'd0, 32'h0000_0000);
        send_item(MODE_START, 3'd0, $urandom());
        send_item(MODE_STEP, 3'd5, $urandom());
    endtask

    task automatic test_data_bus_fault();
        send_item(MODE_START, 3'd1, 32'hFFFF_FFFF);
        repeat (3) step(0);
        send_item(MODE_STEP, 3'd0, ~mst_expect);
        step(0);
    endtask

    task automatic test_single_word();
        configure(32'hFFFF_FFFF, 32'd0);
        send_item(MODE_START, 3'd6, $urandom());
        run_to_end(0, 20);
    endtask

    task automatic test_restart();
        configure(32'h3FFF_FFF8, 32'hFFFF_FFFF);
        send_item(MODE_START, 3'd4, $urandom());
        repeat (3) step(0);
        send_item(MODE_START, 3'd2, $urandom());
        repeat (3) step(0);
        send_item(MODE_START, 3'd1, $urandom());
        step(0);
    endtask

    task automatic test_random_runs();
        logic [31:0] base;
        logic [31:0] region;
        int bad_pct;
        int limit;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 3))
                    0: base = 32'd0;
                    1: base = 32'h3FFF_FFFF;
                    default: base = $urandom();
                endcase
                case ($urandom_range(0, 9))
                    0: region = 32'd0;
                    1: region = 32'd1;
                    2: region = 32'(REGION_TOP);
                    3: region = 32'hFFFF_FFFF;
                    default: region = $urandom_range(2, 40);
                endcase
                configure(base, region);
            end
            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
                0: bad_pct = 0;
                1: bad_pct = 1;
                2: bad_pct = 5;
                default: bad_pct = 20;
            endcase
            // big regions only get partway into the device test
            limit = (region_size() > 64) ? $urandom_range(5, 150) : 100000;
            send_item(MODE_START, 3'($urandom_range(0, 7)), $urandom());
            run_to_end(bad_pct, limit);
            if ($urandom_range(0, 3) == 0) step(bad_pct);
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_full_address_bus();
        configure($urandom(), 32'(REGION_TOP));
        send_item(MODE_START, 3'd3, $urandom());
        run_to_end(0, 100000);
    endtask

    initial begin
        reset_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_and_empty();
        test_data_bus_fault();
        test_single_word();
        test_restart();
        test_random_runs();
        test_full_address_bus();
        drain();
        repeat (5) @(posedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
